// ----- rtl/core/twi_es_pkg.sv -----
package twi_es_pkg;

  // Buffer geometry, fixed by the 6-bit count and 5-bit index fields
  localparam int unsigned BUF_DEPTH = 32;
  localparam int unsigned BUF_AW    = 5;

  // Stream payload widths (byte padded)
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;

  // Item kinds
  typedef enum logic [2:0] {
    CMD_EVENT  = 3'd0,
    CMD_MWRITE = 3'd1,
    CMD_MREAD  = 3'd2,
    CMD_BWRITE = 3'd3,
    CMD_BREAD  = 3'd4
  } cmd_t;

  // Bus actions
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_ACK     = 3'd1,
    ACT_NACK    = 3'd2,
    ACT_START   = 3'd3,
    ACT_LOAD    = 3'd4,
    ACT_STOP    = 3'd5,
    ACT_HOLD    = 3'd6,
    ACT_RELEASE = 3'd7
  } action_t;

  // Controller mode
  typedef enum logic [2:0] {
    PH_READY = 3'd0,
    PH_MTX   = 3'd1,
    PH_MRX   = 3'd2,
    PH_SRX   = 3'd3,
    PH_STX   = 3'd4
  } phase_t;

  // Error codes (dense)
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_ADDR_TX   = 3'd1;
  localparam logic [2:0] ERR_DATA_NACK = 3'd2;
  localparam logic [2:0] ERR_ARB_LOST  = 3'd3;
  localparam logic [2:0] ERR_ADDR_RX   = 3'd4;
  localparam logic [2:0] ERR_SLV_NACK  = 3'd5;
  localparam logic [2:0] ERR_BUS       = 3'd6;

  // TWI status codes
  localparam logic [7:0] ST_BUS_ERR     = 8'h00;
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RESTART     = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK  = 8'h18;
  localparam logic [7:0] ST_MT_SLA_NACK = 8'h20;
  localparam logic [7:0] ST_MT_DAT_ACK  = 8'h28;
  localparam logic [7:0] ST_MT_DAT_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_MR_SLA_ACK  = 8'h40;
  localparam logic [7:0] ST_MR_SLA_NACK = 8'h48;
  localparam logic [7:0] ST_MR_DAT_ACK  = 8'h50;
  localparam logic [7:0] ST_MR_DAT_NACK = 8'h58;
  localparam logic [7:0] ST_SR_SLA_ACK  = 8'h60;
  localparam logic [7:0] ST_SR_ARB_SLA  = 8'h68;
  localparam logic [7:0] ST_SR_GCALL    = 8'h70;
  localparam logic [7:0] ST_SR_ARB_GC   = 8'h78;
  localparam logic [7:0] ST_SR_DAT_ACK  = 8'h80;
  localparam logic [7:0] ST_SR_DAT_NACK = 8'h88;
  localparam logic [7:0] ST_SR_GC_ACK   = 8'h90;
  localparam logic [7:0] ST_SR_GC_NACK  = 8'h98;
  localparam logic [7:0] ST_SR_STOP     = 8'hA0;
  localparam logic [7:0] ST_ST_SLA_ACK  = 8'hA8;
  localparam logic [7:0] ST_ST_ARB_SLA  = 8'hB0;
  localparam logic [7:0] ST_ST_DAT_ACK  = 8'hB8;
  localparam logic [7:0] ST_ST_DAT_NACK = 8'hC0;
  localparam logic [7:0] ST_ST_LAST_ACK = 8'hC8;

  // Configuration register indexes
  localparam logic CFG_SLV_TX_MODE = 1'b0;
  localparam logic CFG_SLV_TX_LEN  = 1'b1;

  // One input item
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  status;
    logic [7:0]  bus_byte;
    logic [6:0]  target_address;
    logic [5:0]  length;
    logic        stop_at_end;
    logic [4:0]  entry_index;
    logic [7:0]  entry_value;
  } item_t;

  // One result item
  typedef struct packed {
    action_t     action;
    logic [7:0]  byte_out;
    phase_t      mode;
    logic [2:0]  error_code;
    logic [5:0]  count;
    logic [7:0]  read_value;
    logic        receive_done;
    logic        rejected;
  } result_t;

  // Buffer write port
  typedef struct packed {
    logic              en;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

endpackage

// ----- rtl/core/twi_es_buffer.sv -----
module twi_es_buffer #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]          wdata,
  input  logic                      re,
  input  logic [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port; no reset, contents undefined until written
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/twi_es_core.sv -----
module twi_es_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [5:0]            cfg_data,
  input  logic                  fire,
  input  logic                  load,
  input  twi_es_pkg::item_t     next_item,
  input  twi_es_pkg::item_t     item,
  output twi_es_pkg::result_t   res
);

  localparam logic [5:0] DEPTH6 = 6'(twi_es_pkg::BUF_DEPTH);

  // Sequencer state
  logic [5:0]          position, position_next;
  logic [5:0]          limit, limit_next;
  twi_es_pkg::phase_t  phase, phase_next;
  logic [2:0]          fault, fault_next;
  logic                stop_after, stop_after_next;
  logic                restart_pending, restart_pending_next;
  logic [7:0]          address_byte, address_byte_next;

  // Configuration
  logic                slave_tx_mode;
  logic [5:0]          slave_tx_length;
  logic [5:0]          stx_limit;

  // Buffer access
  twi_es_pkg::buf_wr_t                buf_wr;
  logic [twi_es_pkg::BUF_AW-1:0]      buf_raddr;
  logic [7:0]                         buf_rdata;
  logic [7:0]                         buf_byte;
  logic [5:0]                         pos_after;
  logic                               rd_hit;
  logic                               byp_hit;
  logic [7:0]                         byp_data;
  logic [5:0]                         pos_taken;
  logic                               can_send;
  logic [7:0]                         addr_new;

  twi_es_buffer #(
    .WIDTH (8),
    .DEPTH (twi_es_pkg::BUF_DEPTH)
  ) u_buffer (
    .clk   (clk),
    .we    (buf_wr.en),
    .waddr (buf_wr.addr),
    .wdata (buf_wr.data),
    .re    (load),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_tx_mode   <= 1'b0;
      slave_tx_length <= 6'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        twi_es_pkg::CFG_SLV_TX_MODE: slave_tx_mode   <= cfg_data[0];
        twi_es_pkg::CFG_SLV_TX_LEN:  slave_tx_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Slave transmit length clamped to 1..depth
  always_comb begin
    if (slave_tx_length == 6'd0) begin
      stx_limit = 6'd1;
    end else if (slave_tx_length > DEPTH6) begin
      stx_limit = DEPTH6;
    end else begin
      stx_limit = slave_tx_length;
    end
  end

  // Buffer read address for the item being loaded: software read, first byte of a
  // slave transmit, or the next byte to send from the position after this edge
  assign pos_after = fire ? position_next : position;

  always_comb begin
    buf_raddr = pos_after[twi_es_pkg::BUF_AW-1:0];
    if (next_item.cmd == twi_es_pkg::CMD_BREAD) begin
      buf_raddr = next_item.entry_index;
    end else if (next_item.cmd == twi_es_pkg::CMD_EVENT &&
                 (next_item.status == twi_es_pkg::ST_ST_SLA_ACK ||
                  next_item.status == twi_es_pkg::ST_ST_ARB_SLA)) begin
      buf_raddr = '0;
    end
  end

  // Forward a byte written at the same edge as the read
  assign rd_hit = buf_wr.en && (buf_wr.addr == buf_raddr);

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else if (load) begin
      byp_hit <= rd_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (load && rd_hit) begin
      byp_data <= buf_wr.data;
    end
  end

  assign buf_byte  = byp_hit ? byp_data : buf_rdata;
  assign can_send  = (position < limit) && (position < DEPTH6);
  assign pos_taken = (position < DEPTH6) ? position + 6'd1 : position;
  assign addr_new  = {item.target_address, item.cmd == twi_es_pkg::CMD_MREAD};

  // Decision logic for one item
  always_comb begin
    position_next        = position;
    limit_next           = limit;
    phase_next           = phase;
    fault_next           = fault;
    stop_after_next      = stop_after;
    restart_pending_next = restart_pending;
    address_byte_next    = address_byte;
    buf_wr               = '0;
    res                  = '0;
    res.action           = twi_es_pkg::ACT_NONE;

    unique case (item.cmd)
      twi_es_pkg::CMD_MWRITE, twi_es_pkg::CMD_MREAD: begin
        if (phase != twi_es_pkg::PH_READY || item.length > DEPTH6) begin
          res.rejected = 1'b1;
        end else begin
          phase_next        = (item.cmd == twi_es_pkg::CMD_MWRITE) ? twi_es_pkg::PH_MTX
                                                                  : twi_es_pkg::PH_MRX;
          stop_after_next   = item.stop_at_end;
          fault_next        = twi_es_pkg::ERR_NONE;
          position_next     = 6'd0;
          if (item.cmd == twi_es_pkg::CMD_MWRITE || item.length == 6'd0) begin
            limit_next = item.length;
          end else begin
            limit_next = item.length - 6'd1;
          end
          address_byte_next = addr_new;
          if (restart_pending) begin
            restart_pending_next = 1'b0;
            res.byte_out         = addr_new;
            res.action           = twi_es_pkg::ACT_LOAD;
          end else begin
            res.action = twi_es_pkg::ACT_START;
          end
        end
      end
      twi_es_pkg::CMD_BWRITE: begin
        buf_wr.en   = 1'b1;
        buf_wr.addr = item.entry_index;
        buf_wr.data = item.entry_value;
      end
      twi_es_pkg::CMD_BREAD: begin
        res.read_value = buf_byte;
      end
      twi_es_pkg::CMD_EVENT: begin
        unique case (item.status) inside
          twi_es_pkg::ST_START, twi_es_pkg::ST_RESTART: begin
            res.byte_out = address_byte;
            res.action   = twi_es_pkg::ACT_LOAD;
          end
          twi_es_pkg::ST_MT_SLA_ACK, twi_es_pkg::ST_MT_DAT_ACK,
          twi_es_pkg::ST_ST_DAT_ACK: begin
            // send next buffered byte or finish the transfer
            if (can_send) begin
              res.byte_out  = buf_byte;
              position_next = position + 6'd1;
              res.action    = twi_es_pkg::ACT_LOAD;
            end else begin
              phase_next = twi_es_pkg::PH_READY;
              if (stop_after) begin
                res.action = twi_es_pkg::ACT_STOP;
              end else begin
                restart_pending_next = 1'b1;
                res.action           = twi_es_pkg::ACT_HOLD;
              end
            end
          end
          twi_es_pkg::ST_MT_SLA_NACK: begin
            fault_next = twi_es_pkg::ERR_ADDR_TX;
            res.action = twi_es_pkg::ACT_STOP;
            phase_next = twi_es_pkg::PH_READY;
          end
          twi_es_pkg::ST_MT_DAT_NACK: begin
            fault_next = twi_es_pkg::ERR_DATA_NACK;
            res.action = twi_es_pkg::ACT_STOP;
            phase_next = twi_es_pkg::PH_READY;
          end
          twi_es_pkg::ST_ARB_LOST: begin
            fault_next = twi_es_pkg::ERR_ARB_LOST;
            res.action = twi_es_pkg::ACT_STOP;
            phase_next = twi_es_pkg::PH_READY;
          end
          twi_es_pkg::ST_MR_SLA_NACK: begin
            fault_next = twi_es_pkg::ERR_ADDR_RX;
            res.action = twi_es_pkg::ACT_STOP;
            phase_next = twi_es_pkg::PH_READY;
          end
          twi_es_pkg::ST_BUS_ERR: begin
            fault_next = twi_es_pkg::ERR_BUS;
            res.action = twi_es_pkg::ACT_STOP;
            phase_next = twi_es_pkg::PH_READY;
          end
          twi_es_pkg::ST_MR_SLA_ACK: begin
            res.action = (position < limit) ? twi_es_pkg::ACT_ACK : twi_es_pkg::ACT_NACK;
          end
          twi_es_pkg::ST_MR_DAT_ACK, twi_es_pkg::ST_SR_DAT_ACK,
          twi_es_pkg::ST_SR_GC_ACK: begin
            // store received byte, then ask for more if wanted
            buf_wr.en     = (position < DEPTH6);
            buf_wr.addr   = position[twi_es_pkg::BUF_AW-1:0];
            buf_wr.data   = item.bus_byte;
            position_next = pos_taken;
            res.action    = (pos_taken < limit) ? twi_es_pkg::ACT_ACK : twi_es_pkg::ACT_NACK;
          end
          twi_es_pkg::ST_MR_DAT_NACK: begin
            buf_wr.en     = (position < DEPTH6);
            buf_wr.addr   = position[twi_es_pkg::BUF_AW-1:0];
            buf_wr.data   = item.bus_byte;
            position_next = pos_taken;
            phase_next    = twi_es_pkg::PH_READY;
            if (stop_after) begin
              res.action = twi_es_pkg::ACT_STOP;
            end else begin
              restart_pending_next = 1'b1;
              res.action           = twi_es_pkg::ACT_HOLD;
            end
          end
          twi_es_pkg::ST_SR_SLA_ACK, twi_es_pkg::ST_SR_ARB_SLA,
          twi_es_pkg::ST_SR_GCALL, twi_es_pkg::ST_SR_ARB_GC: begin
            phase_next    = twi_es_pkg::PH_SRX;
            position_next = 6'd0;
            limit_next    = DEPTH6;
            res.action    = twi_es_pkg::ACT_ACK;
          end
          twi_es_pkg::ST_SR_STOP: begin
            res.receive_done = 1'b1;
            position_next    = 6'd0;
            limit_next       = DEPTH6;
            phase_next       = twi_es_pkg::PH_READY;
            res.action       = twi_es_pkg::ACT_RELEASE;
          end
          twi_es_pkg::ST_SR_DAT_NACK, twi_es_pkg::ST_SR_GC_NACK: begin
            fault_next = twi_es_pkg::ERR_SLV_NACK;
          end
          twi_es_pkg::ST_ST_SLA_ACK, twi_es_pkg::ST_ST_ARB_SLA: begin
            // address match as transmitter: load first byte at once
            phase_next    = twi_es_pkg::PH_STX;
            position_next = 6'd1;
            res.action    = twi_es_pkg::ACT_LOAD;
            if (slave_tx_mode) begin
              limit_next   = stx_limit;
              res.byte_out = buf_byte;
            end else begin
              limit_next   = 6'd1;
              buf_wr.en    = 1'b1;
              buf_wr.addr  = '0;
              buf_wr.data  = 8'h00;
              res.byte_out = 8'h00;
            end
          end
          twi_es_pkg::ST_ST_DAT_NACK, twi_es_pkg::ST_ST_LAST_ACK: begin
            res.action = twi_es_pkg::ACT_ACK;
            phase_next = twi_es_pkg::PH_READY;
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    if (!fire) begin
      buf_wr.en = 1'b0;
    end

    res.mode       = phase_next;
    res.error_code = fault_next;
    // a slave stop reports the count before it clears
    res.count      = res.receive_done ? position : position_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      position        <= 6'd0;
      limit           <= 6'd0;
      phase           <= twi_es_pkg::PH_READY;
      fault           <= twi_es_pkg::ERR_NONE;
      stop_after      <= 1'b1;
      restart_pending <= 1'b0;
      address_byte    <= 8'h00;
    end else if (fire) begin
      position        <= position_next;
      limit           <= limit_next;
      phase           <= phase_next;
      fault           <= fault_next;
      stop_after      <= stop_after_next;
      restart_pending <= restart_pending_next;
      address_byte    <= address_byte_next;
    end
  end

endmodule

// ----- rtl/core/twi_event_sequencer_top.sv -----
// Each item passes the input register, then the result register on m_tdata; the
// buffer byte is read at the input transfer, the decision is one combinational pass.
// Throughput: one item per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset (rst, synchronous): empties both registers, returns the sequencer to
// ready with no error, configuration to mode 0 and length 1; buffer undefined.
module twi_event_sequencer_top (
  input  logic         clk,
  input  logic         rst,
  // configuration
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [5:0]   cfg_data,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // status, bus_byte, target_address, length,
                                  // stop_at_end, entry_index, entry_value, zero pad
  input  logic [2:0]   s_tuser,   // cmd
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata    // action, byte_out, mode, error_code, count,
                                  // read_value, receive_done, rejected, zero pad
);

  logic                 in_valid;
  twi_es_pkg::item_t    next_item;
  twi_es_pkg::item_t    in_item;
  twi_es_pkg::result_t  res_next;
  twi_es_pkg::result_t  res;
  logic                 advance;
  logic                 fire;
  logic                 load;

  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;
  assign load     = s_tvalid && s_tready;

  // Unpack the offered transfer
  assign next_item.cmd            = twi_es_pkg::cmd_t'(s_tuser);
  assign next_item.status         = s_tdata[7:0];
  assign next_item.bus_byte       = s_tdata[15:8];
  assign next_item.target_address = s_tdata[22:16];
  assign next_item.length         = s_tdata[28:23];
  assign next_item.stop_at_end    = s_tdata[29];
  assign next_item.entry_index    = s_tdata[34:30];
  assign next_item.entry_value    = s_tdata[42:35];

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      in_item <= next_item;
    end
  end

  twi_es_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .load      (load),
    .next_item (next_item),
    .item      (in_item),
    .res       (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign m_tdata = {7'd0, res.rejected, res.receive_done, res.read_value, res.count,
                    res.error_code, res.mode, res.byte_out, res.action};

endmodule

// ----- dv/twi_event_sequencer_top_test.sv -----
`timescale 1ns / 1ps

module twi_event_sequencer_top_test;
  import twi_es_pkg::*;

  // Predicts the sequencer's answer to every accepted item and checks results in order
  class twi_scoreboard;
    result_t expected_q[$];
    int errors;
    int checked;

    // sequencer state
    logic [7:0] store [BUF_DEPTH];
    logic [5:0] position;
    logic [5:0] limit;
    phase_t     phase;
    logic [2:0] fault;
    logic       stop_after;
    logic       restart_pending;
    logic [7:0] address_byte;
    // configuration
    logic       tx_from_buf;
    logic [5:0] tx_len;
    // answer being built
    action_t    act;
    logic [7:0] load_byte;

    function new();
      position = '0;
      limit = '0;
      phase = PH_READY;
      fault = ERR_NONE;
      stop_after = 1'b1;
      restart_pending = 1'b0;
      address_byte = '0;
      tx_from_buf = 1'b0;
      tx_len = 6'd1;
      errors = 0;
      checked = 0;
    endfunction

    function void set_config(logic idx, logic [5:0] val);
      if (idx == CFG_SLV_TX_MODE) begin
        tx_from_buf = val[0];
      end else begin
        tx_len = val;
      end
    endfunction

    function void end_transfer();
      if (stop_after) begin
        act = ACT_STOP;
      end else begin
        restart_pending = 1'b1;
        act = ACT_HOLD;
      end
      phase = PH_READY;
    endfunction

    function void load_next();
      if (position < limit && position < BUF_DEPTH) begin
        load_byte = store[position[4:0]];
        position++;
        act = ACT_LOAD;
      end else begin
        end_transfer();
      end
    endfunction

    // bytes past the end of the buffer are dropped
    function void capture(logic [7:0] b);
      if (position < BUF_DEPTH) begin
        store[position[4:0]] = b;
        position++;
      end
    endfunction

    function void abort(logic [2:0] code);
      fault = code;
      act = ACT_STOP;
      phase = PH_READY;
    endfunction

    function void note_input(item_t it);
      result_t r;
      logic [5:0] stop_count;
      logic count_held;
      r = '0;
      act = ACT_NONE;
      load_byte = '0;
      count_held = 1'b0;
      stop_count = '0;
      case (it.cmd)
        CMD_MWRITE, CMD_MREAD: begin
          // busy or oversized requests change nothing
          if (phase != PH_READY || it.length > BUF_DEPTH) begin
            r.rejected = 1'b1;
          end else begin
            phase = (it.cmd == CMD_MWRITE) ? PH_MTX : PH_MRX;
            stop_after = it.stop_at_end;
            fault = ERR_NONE;
            position = '0;
            if (it.cmd == CMD_MWRITE) begin
              limit = it.length;
            end else begin
              limit = (it.length == 0) ? 6'd0 : it.length - 6'd1;
            end
            address_byte = {it.target_address, it.cmd == CMD_MREAD};
            if (restart_pending) begin
              restart_pending = 1'b0;
              load_byte = address_byte;
              act = ACT_LOAD;
            end else begin
              act = ACT_START;
            end
          end
        end
        CMD_BWRITE: store[it.entry_index] = it.entry_value;
        CMD_BREAD: r.read_value = store[it.entry_index];
        CMD_EVENT: begin
          case (it.status)
            ST_START, ST_RESTART: begin
              load_byte = address_byte;
              act = ACT_LOAD;
            end
            ST_MT_SLA_ACK, ST_MT_DAT_ACK, ST_ST_DAT_ACK: load_next();
            ST_MT_SLA_NACK: abort(ERR_ADDR_TX);
            ST_MT_DAT_NACK: abort(ERR_DATA_NACK);
            ST_ARB_LOST: abort(ERR_ARB_LOST);
            ST_MR_SLA_NACK: abort(ERR_ADDR_RX);
            ST_BUS_ERR: abort(ERR_BUS);
            ST_MR_SLA_ACK: act = (position < limit) ? ACT_ACK : ACT_NACK;
            ST_MR_DAT_ACK, ST_SR_DAT_ACK, ST_SR_GC_ACK: begin
              capture(it.bus_byte);
              act = (position < limit) ? ACT_ACK : ACT_NACK;
            end
            ST_MR_DAT_NACK: begin
              capture(it.bus_byte);
              end_transfer();
            end
            ST_SR_SLA_ACK, ST_SR_ARB_SLA, ST_SR_GCALL, ST_SR_ARB_GC: begin
              phase = PH_SRX;
              position = '0;
              limit = 6'(BUF_DEPTH);
              act = ACT_ACK;
            end
            ST_SR_STOP: begin
              // report the received count, then clear for the next receive
              r.receive_done = 1'b1;
              stop_count = position;
              count_held = 1'b1;
              position = '0;
              limit = 6'(BUF_DEPTH);
              phase = PH_READY;
              act = ACT_RELEASE;
            end
            ST_SR_DAT_NACK, ST_SR_GC_NACK: fault = ERR_SLV_NACK;
            ST_ST_SLA_ACK, ST_ST_ARB_SLA: begin
              phase = PH_STX;
              position = '0;
              if (tx_from_buf) begin
                limit = tx_len;
                if (limit < 1) limit = 6'd1;
                if (limit > BUF_DEPTH) limit = 6'(BUF_DEPTH);
              end else begin
                limit = 6'd1;
                store[0] = 8'h00;
              end
              load_next();
            end
            ST_ST_DAT_NACK, ST_ST_LAST_ACK: begin
              act = ACT_ACK;
              phase = PH_READY;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      r.action = act;
      r.byte_out = load_byte;
      r.mode = phase;
      r.error_code = fault;
      r.count = count_held ? stop_count : position;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want) begin
        report_mismatch($sformatf("result %0d %s: got %0h, want %0h", checked, name, got, want));
      end
    endtask

    task check_result(logic [39:0] d);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0h with nothing expected", d));
      end else begin
        want = expected_q.pop_front();
        compare_field("action", d[2:0], want.action);
        compare_field("byte_out", d[10:3], want.byte_out);
        compare_field("mode", d[13:11], want.mode);
        compare_field("error_code", d[16:14], want.error_code);
        compare_field("count", d[22:17], want.count);
        compare_field("read_value", d[30:23], want.read_value);
        compare_field("receive_done", d[31], want.receive_done);
        compare_field("rejected", d[32], want.rejected);
      end
      checked++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [5:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // status, bus_byte, target_address, length,
                               // stop_at_end, entry_index, entry_value, zero pad
  logic [2:0]  s_tuser = '0;   // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // action, byte_out, mode, error_code, count,
                               // read_value, receive_done, rejected, zero pad

  twi_scoreboard sb = new();

  int items_sent = 0;
  int burst_left = 1;
  int results_seen = 0;
  int hold_left = 0;
  bit held = 1'b0;
  int stall_pct = 0;
  int rx_cycle = 0;

  twi_event_sequencer_top DUT (.*);

  always #1 clk = ~clk;

  // Result side: check each transfer, stall on a shifting pattern, one long hold-off
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata);
      results_seen++;
    end
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (results_seen >= 300 && !held) begin
      held = 1'b1;
      hold_left = 250;
      m_tready <= 1'b0;
    end else begin
      if (rx_cycle % 64 == 0) begin
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 25;
          3: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic item_t rand_item();
    item_t it;
    it.cmd = cmd_t'($urandom_range(0, 7));
    it.status = 8'($urandom);
    it.bus_byte = 8'($urandom);
    it.target_address = 7'($urandom);
    it.length = 6'($urandom);
    it.stop_at_end = 1'($urandom);
    it.entry_index = 5'($urandom);
    it.entry_value = 8'($urandom);
    return it;
  endfunction

  function automatic item_t event_item(logic [7:0] st);
    item_t it;
    it = rand_item();
    it.cmd = CMD_EVENT;
    it.status = st;
    return it;
  endfunction

  function automatic item_t request_item(cmd_t c, int len, logic stop);
    item_t it;
    it = rand_item();
    it.cmd = c;
    it.length = 6'(len);
    it.stop_at_end = stop;
    return it;
  endfunction

  function automatic item_t buffer_item(cmd_t c, int idx, int val);
    item_t it;
    it = rand_item();
    it.cmd = c;
    it.entry_index = 5'(idx);
    it.entry_value = 8'(val);
    return it;
  endfunction

  // mostly short transfers, some up to the full buffer, a few oversized
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 8);
    if (r < 92) return $urandom_range(9, 32);
    return $urandom_range(33, 63);
  endfunction

  // Offer one item and wait for its transfer; bursts end in a random gap, which may be zero
  task automatic send(item_t it);
    int gap;
    s_tdata <= {5'b0, it.entry_value, it.entry_index, it.stop_at_end, it.length,
                it.target_address, it.bus_byte, it.status};
    s_tuser <= it.cmd;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(it);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering, let every expected result arrive, then cover the pipeline latency
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One write cycle, then one quiet cycle so consecutive writes never collide
  task automatic write_register(logic idx, logic [5:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(idx, val);
    @(posedge clk);
  endtask

  // Hand-picked corner cases, run with the reset configuration
  task automatic directed_items();
    item_t it;
    send(buffer_item(CMD_BWRITE, 31, 8'hFF));
    send(buffer_item(CMD_BREAD, 31, 0));
    send(buffer_item(CMD_BREAD, 0, 0));
    it = request_item(CMD_MWRITE, 2, 1'b0);
    it.target_address = 7'h7F;
    send(it);
    send(request_item(CMD_MWRITE, 1, 1'b1));        // busy
    send(event_item(ST_START));
    send(event_item(ST_MT_SLA_ACK));
    send(event_item(ST_MT_DAT_ACK));
    send(event_item(ST_MT_DAT_ACK));                 // hold for repeated start
    it = request_item(CMD_MREAD, 0, 1'b1);           // zero-length read via restart
    it.target_address = '0;
    send(it);
    send(event_item(ST_MR_SLA_ACK));
    it = event_item(ST_MR_DAT_NACK);
    it.bus_byte = 8'hFF;
    send(it);
    send(request_item(CMD_MREAD, 33, 1'b1));        // oversized
    send(event_item(ST_BUS_ERR));
    send(event_item(ST_SR_SLA_ACK));
    it = event_item(ST_SR_DAT_ACK);
    it.bus_byte = 8'h00;
    send(it);
    send(event_item(ST_SR_DAT_NACK));
    send(event_item(ST_SR_STOP));
    send(event_item(ST_ST_SLA_ACK));                 // zero byte as slave transmitter
    send(event_item(ST_ST_LAST_ACK));
    send(event_item(8'hFF));                         // unknown status
    it = rand_item();
    it.cmd = cmd_t'(3'd7);                           // unknown command
    send(it);
    send(request_item(CMD_MWRITE, 1, 1'b1));
    send(event_item(ST_START));
    send(event_item(ST_MT_SLA_NACK));
  endtask

  // One well-formed bus transaction with random content, software buffer accesses, or some noise
  task automatic run_sequence();
    int kind;
    int n;
    int i;
    item_t it;
    kind = $urandom_range(0, 99);
    if (kind < 22) begin
      // master write
      n = pick_length();
      send(request_item(CMD_MWRITE, n, 1'($urandom_range(0, 1))));
      if ($urandom_range(0, 9) == 0) send(request_item(CMD_MREAD, pick_length(), 1'b1));
      send(event_item($urandom_range(0, 1) ? ST_START : ST_RESTART));
      case ($urandom_range(0, 11))
        0: send(event_item(ST_MT_SLA_NACK));
        1: send(event_item(ST_ARB_LOST));
        2: send(event_item(ST_BUS_ERR));
        default: begin
          send(event_item(ST_MT_SLA_ACK));
          for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 29) == 0) begin
              send(event_item(ST_MT_DAT_NACK));
              break;
            end
            send(event_item(ST_MT_DAT_ACK));
          end
        end
      endcase
    end else if (kind < 44) begin
      // master read
      n = pick_length();
      send(request_item(CMD_MREAD, n, 1'($urandom_range(0, 1))));
      send(event_item($urandom_range(0, 1) ? ST_START : ST_RESTART));
      if ($urandom_range(0, 9) == 0) begin
        send(event_item(ST_MR_SLA_NACK));
      end else begin
        send(event_item(ST_MR_SLA_ACK));
        for (i = 0; i + 1 < n; i++) send(event_item(ST_MR_DAT_ACK));
        send(event_item(ST_MR_DAT_NACK));
      end
    end else if (kind < 64) begin
      // slave receive, sometimes past the end of the buffer
      case ($urandom_range(0, 3))
        0: send(event_item(ST_SR_SLA_ACK));
        1: send(event_item(ST_SR_ARB_SLA));
        2: send(event_item(ST_SR_GCALL));
        default: send(event_item(ST_SR_ARB_GC));
      endcase
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 36) : $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
        case ($urandom_range(0, 39))
          0: send(event_item(ST_SR_DAT_NACK));
          1: send(event_item(ST_SR_GC_NACK));
          2, 3, 4, 5, 6, 7, 8, 9: send(event_item(ST_SR_GC_ACK));
          default: send(event_item(ST_SR_DAT_ACK));
        endcase
      end
      send(event_item(ST_SR_STOP));
    end else if (kind < 82) begin
      // slave transmit
      send(event_item($urandom_range(0, 1) ? ST_ST_SLA_ACK : ST_ST_ARB_SLA));
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 34) : $urandom_range(0, 6);
      for (i = 0; i < n; i++) send(event_item(ST_ST_DAT_ACK));
      send(event_item($urandom_range(0, 1) ? ST_ST_DAT_NACK : ST_ST_LAST_ACK));
    end else if (kind < 92) begin
      // software buffer accesses
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
        send(buffer_item($urandom_range(0, 1) ? CMD_BWRITE : CMD_BREAD,
                         $urandom_range(0, 31), $urandom_range(0, 255)));
      end
    end else begin
      // noise: anything the fields allow
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
        it = rand_item();
        if ($urandom_range(0, 1) == 0) it.cmd = CMD_EVENT;
        send(it);
      end
    end
  endtask

  // Stimulus
  initial begin
    logic [5:0] tx_lengths [6];
    logic       tx_modes [6];
    int p;
    int i;
    int target;
    tx_modes = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    tx_lengths = '{6'd32, 6'd1, 6'd5, 6'd0, 6'd63, 6'd0};
    tx_lengths[5] = 6'($urandom_range(2, 31));
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // every buffer entry gets a value before anything can read it
    for (i = 0; i < BUF_DEPTH; i++) send(buffer_item(CMD_BWRITE, i, $urandom_range(0, 255)));
    directed_items();
    wait_idle();
    for (p = 0; p < 6; p++) begin
      write_register(CFG_SLV_TX_MODE, {5'b0, tx_modes[p]});
      write_register(CFG_SLV_TX_LEN, tx_lengths[p]);
      target = items_sent + 250;
      while (items_sent < target) run_sequence();
      wait_idle();
    end
    repeat (8) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
    end
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/twi_es_pkg.sv
rtl/core/twi_es_buffer.sv
rtl/core/twi_es_core.sv
rtl/core/twi_event_sequencer_top.sv
dv/twi_event_sequencer_top_test.sv
